/* rtl/pilc_pkg.sv */
// Package for the PI current loop: types, constants, saturation and the control-word program.
package pilc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LIM_W   = 31;
    localparam int unsigned DUTY_W  = 26;
    localparam int unsigned DUTY_SH = 5;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned PROD_W  = 2 * DATA_W;
    localparam int unsigned TERM_W  = PROD_W - FRAC_W;
    localparam int unsigned ACC_W   = TERM_W + 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned STEP_W  = 4;

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_NOW  = 3'd0,
        REG_GAIN_PREV = 3'd1,
        REG_MODEL_CUR = 3'd2,
        REG_MODEL_SPD = 3'd3,
        REG_MODEL_DRV = 3'd4,
        REG_LIMIT     = 3'd5
    } t_reg_idx;

    localparam logic signed [DATA_W-1:0] RST_GAIN_NOW  = 32'sd3015;
    localparam logic signed [DATA_W-1:0] RST_GAIN_PREV = 32'sd918;
    localparam logic signed [DATA_W-1:0] RST_MODEL_CUR = -32'sd24805;
    localparam logic signed [DATA_W-1:0] RST_MODEL_SPD = -32'sd1861;
    localparam logic signed [DATA_W-1:0] RST_MODEL_DRV = 32'sd31824;
    localparam logic [LIM_W-1:0]         RST_LIMIT     = 31'd786432;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_now;
        logic signed [DATA_W-1:0] gain_prev;
        logic signed [DATA_W-1:0] model_cur;
        logic signed [DATA_W-1:0] model_spd;
        logic signed [DATA_W-1:0] model_drv;
        logic [LIM_W-1:0]         limit;
    } t_cfg;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        SA_GAIN_NOW  = 3'd0,
        SA_GAIN_PREV = 3'd1,
        SA_MODEL_CUR = 3'd2,
        SA_MODEL_SPD = 3'd3,
        SA_MODEL_DRV = 3'd4
    } t_sel_a;

    typedef enum logic [2:0] {
        SB_ERR  = 3'd0,
        SB_LERR = 3'd1,
        SB_EST  = 3'd2,
        SB_LSPD = 3'd3,
        SB_DSUM = 3'd4
    } t_sel_b;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD = 3'd0,
        ACC_ERR  = 3'd1,   // target minus estimate
        ACC_LD   = 3'd2,   // load last drive
        ACC_ADDP = 3'd3,   // add rounded product
        ACC_DSUM = 3'd4,   // saturated accumulator plus last drive
        ACC_P    = 3'd5    // load rounded product
    } t_acc_op;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_ERR  = 2'd1,
        WR_DRV  = 2'd2,
        WR_DSUM = 2'd3
    } t_wr;

    typedef enum logic [1:0] {
        CD_NONE     = 2'd0,
        CD_NO_INPUT = 2'd1,
        CD_OUT_BUSY = 2'd2
    } t_cond;

    typedef struct packed {
        logic    mul_en;
        t_sel_a  sel_a;
        t_sel_b  sel_b;
        t_acc_op acc_op;
        t_wr     wr;
        logic    commit;
        t_cond   cond;
        t_step   target;
        logic    last;
    } t_ctrl;

    // Command from the sequencer to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    commit;
        logic    mul_en;
        t_sel_a  sel_a;
        t_sel_b  sel_b;
        t_acc_op acc_op;
        t_wr     wr;
    } t_dp_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } t_dp_res;

    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_COMMIT = 4'd10;

    function automatic t_ctrl cw(logic mul_en, t_sel_a sa, t_sel_b sb, t_acc_op op,
                                 t_wr wr, logic commit, t_cond cond, t_step target,
                                 logic last);
        t_ctrl c;
        c.mul_en = mul_en;
        c.sel_a  = sa;
        c.sel_b  = sb;
        c.acc_op = op;
        c.wr     = wr;
        c.commit = commit;
        c.cond   = cond;
        c.target = target;
        c.last   = last;
        return c;
    endfunction

    // The program. A product taken in one step is added in the next.
    function automatic t_ctrl ctrl_rom(t_step pc);
        t_ctrl c;
        unique case (pc)
            4'd0:  c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_HOLD, WR_NONE, 1'b0,
                          CD_NO_INPUT, STEP_IDLE, 1'b0);
            4'd1:  c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_ERR,  WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd2:  c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_LD,   WR_ERR,  1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd3:  c = cw(1'b1, SA_GAIN_NOW,  SB_ERR,  ACC_HOLD, WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd4:  c = cw(1'b1, SA_GAIN_PREV, SB_LERR, ACC_ADDP, WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd5:  c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_ADDP, WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd6:  c = cw(1'b1, SA_MODEL_CUR, SB_EST,  ACC_DSUM, WR_DRV,  1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd7:  c = cw(1'b1, SA_MODEL_SPD, SB_LSPD, ACC_P,    WR_DSUM, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd8:  c = cw(1'b1, SA_MODEL_DRV, SB_DSUM, ACC_ADDP, WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd9:  c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_ADDP, WR_NONE, 1'b0,
                          CD_NONE, STEP_IDLE, 1'b0);
            4'd10: c = cw(1'b0, SA_GAIN_NOW,  SB_ERR,  ACC_HOLD, WR_NONE, 1'b1,
                          CD_OUT_BUSY, STEP_COMMIT, 1'b1);
            default: c = cw(1'b0, SA_GAIN_NOW, SB_ERR, ACC_HOLD, WR_NONE, 1'b0,
                            CD_NONE, STEP_IDLE, 1'b1);
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > $signed({{(ACC_W-DATA_W){1'b0}}, S32_MAX})) begin
            r = S32_MAX;
        end else if (v < $signed({{(ACC_W-DATA_W){1'b1}}, S32_MIN})) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] ext32(logic signed [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

/* rtl/pilc_if.sv */
// Channel interfaces of the PI current loop: input items, results and register writes.
interface pilc_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        target_current;
    logic signed [31:0]        measured_speed;

    modport source (output valid, output target_current, output measured_speed,
                    input ready);
    modport sink   (input valid, input target_current, input measured_speed,
                    output ready);
endinterface

interface pilc_out_if;
    logic        valid;
    logic        ready;
    logic [25:0] duty;
    logic        clamped;

    modport source (output valid, output duty, output clamped, input ready);
    modport sink   (input valid, input duty, input clamped, output ready);
endinterface

interface pilc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pilc_datapath.sv */
// Datapath of the PI current loop: shared multiplier, accumulator and loop state.
module pilc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pilc_pkg::t_dp_cmd                 i_cmd,
    input  pilc_pkg::t_cfg                    i_cfg,
    input  logic signed [pilc_pkg::DATA_W-1:0] i_target,
    input  logic signed [pilc_pkg::DATA_W-1:0] i_speed,
    output pilc_pkg::t_dp_res                 o_res
);
    import pilc_pkg::*;

    logic signed [DATA_W-1:0] r_target, r_speed;
    logic signed [DATA_W-1:0] r_err, r_drive, r_dsum;
    logic signed [DATA_W-1:0] r_est, r_last_speed, r_last_err, r_last_drive;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [ACC_W-1:0]  term;
    logic signed [DATA_W-1:0] acc_sat;
    logic signed [DATA_W-1:0] held;
    logic signed [DATA_W-1:0] limit_s;
    logic                     clip;

    always_comb begin
        unique case (i_cmd.sel_a)
            SA_GAIN_NOW:  mul_a = i_cfg.gain_now;
            SA_GAIN_PREV: mul_a = i_cfg.gain_prev;
            SA_MODEL_CUR: mul_a = i_cfg.model_cur;
            SA_MODEL_SPD: mul_a = i_cfg.model_spd;
            SA_MODEL_DRV: mul_a = i_cfg.model_drv;
            default:      mul_a = i_cfg.gain_now;
        endcase
        unique case (i_cmd.sel_b)
            SB_ERR:  mul_b = r_err;
            SB_LERR: mul_b = r_last_err;
            SB_EST:  mul_b = r_est;
            SB_LSPD: mul_b = r_last_speed;
            SB_DSUM: mul_b = r_dsum;
            default: mul_b = r_err;
        endcase
    end

    // Round half up to Q16.16: add half an LSB, then an arithmetic shift.
    assign prod_rnd = r_prod + $signed(PROD_W'(1) << (FRAC_W - 1));
    assign term     = {{(ACC_W-TERM_W){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:FRAC_W]};
    assign acc_sat  = sat32(r_acc);

    always_comb begin
        unique case (i_cmd.acc_op)
            ACC_HOLD: n_acc = r_acc;
            ACC_ERR:  n_acc = ext32(r_target) - ext32(r_est);
            ACC_LD:   n_acc = ext32(r_last_drive);
            ACC_ADDP: n_acc = r_acc + term;
            ACC_DSUM: n_acc = ext32(acc_sat) + ext32(r_last_drive);
            ACC_P:    n_acc = term;
            default:  n_acc = r_acc;
        endcase
    end

    // Clamp of the new drive to the range from zero to the limit.
    assign limit_s = $signed({1'b0, i_cfg.limit});
    always_comb begin
        if (r_drive > limit_s) begin
            held = limit_s;
            clip = 1'b1;
        end else if (r_drive[DATA_W-1]) begin
            held = '0;
            clip = 1'b1;
        end else begin
            held = r_drive;
            clip = 1'b0;
        end
    end

    assign o_res.duty    = held[DUTY_SH+DUTY_W-1:DUTY_SH];
    assign o_res.clamped = clip;

    // Working registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_target <= i_target;
            r_speed  <= i_speed;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        r_acc <= n_acc;
        unique case (i_cmd.wr)
            WR_NONE: ;
            WR_ERR:  r_err  <= acc_sat;
            WR_DRV:  r_drive <= acc_sat;
            WR_DSUM: r_dsum <= acc_sat;
            default: ;
        endcase
    end

    // Loop state is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est        <= '0;
            r_last_speed <= '0;
            r_last_err   <= '0;
            r_last_drive <= '0;
        end else if (i_cmd.commit) begin
            r_est        <= acc_sat;
            r_last_speed <= r_speed;
            r_last_err   <= r_err;
            r_last_drive <= held;
        end
    end

endmodule

/* rtl/pi_current_loop_with_estimator_unit.sv */
// Top level of the PI current loop with model-based current estimator.
//
//  Channel   Dir  Handshake     Payload
//  i_in_ch   in   valid/ready   target_current, measured_speed (Q16.16 signed)
//  o_out_ch  out  valid/ready   duty (26 bit), clamped (1 bit)
//  i_cfg     in   valid/ready   index (3 bit), data (32 bit)
//
// An item passes from acceptance to the result register through the eleven steps
// of the control program, which share the single 32x32 multiplier.
// A new item is taken only in the idle step, so the block takes no new item until
// the last one is committed, and commit waits for the output register to empty.
// Reset is synchronous and active low; it restores the register defaults and zeroes
// the estimate, last speed, last error and last drive. Register writes are taken at
// any time outside reset, and no item is taken while reset is held.
module pi_current_loop_with_estimator_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    pilc_in_if.sink    i_in_ch,
    pilc_out_if.source o_out_ch,
    pilc_cfg_if.sink   i_cfg
);
    import pilc_pkg::*;

    t_step   r_pc, n_pc;
    t_ctrl   ctrl;
    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_res res;

    logic              r_o_valid;
    logic [DUTY_W-1:0] r_o_duty;
    logic              r_o_clamped;

    logic in_fire, out_busy, commit_fire, cond_true;

    // Control word of the current step.
    assign ctrl = ctrl_rom(r_pc);

    // Items are taken only while the program sits in its idle step.
    assign i_in_ch.ready = (r_pc == STEP_IDLE) && i_rst_n;
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;

    // The result register is busy while it holds a result the sink has not taken.
    assign out_busy    = r_o_valid && !o_out_ch.ready;
    assign commit_fire = ctrl.commit && !out_busy;

    always_comb begin
        unique case (ctrl.cond)
            CD_NONE:     cond_true = 1'b0;
            CD_NO_INPUT: cond_true = !i_in_ch.valid;
            CD_OUT_BUSY: cond_true = out_busy;
            default:     cond_true = 1'b0;
        endcase
    end

    // Step counter: a taken jump goes to its target, the last step wraps to idle.
    always_comb begin
        if (cond_true) begin
            n_pc = ctrl.target;
        end else if (ctrl.last) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign cmd.load_in = in_fire;
    assign cmd.commit  = commit_fire;
    assign cmd.mul_en  = ctrl.mul_en;
    assign cmd.sel_a   = ctrl.sel_a;
    assign cmd.sel_b   = ctrl.sel_b;
    assign cmd.acc_op  = ctrl.acc_op;
    assign cmd.wr      = ctrl.wr;

    pilc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (r_cfg),
        .i_target (i_in_ch.target_current),
        .i_speed  (i_in_ch.measured_speed),
        .o_res    (res)
    );

    // Configuration registers. Writes to indexes past the limit register are dropped.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_now  <= RST_GAIN_NOW;
            r_cfg.gain_prev <= RST_GAIN_PREV;
            r_cfg.model_cur <= RST_MODEL_CUR;
            r_cfg.model_spd <= RST_MODEL_SPD;
            r_cfg.model_drv <= RST_MODEL_DRV;
            r_cfg.limit     <= RST_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_GAIN_NOW:  r_cfg.gain_now  <= $signed(i_cfg.data);
                REG_GAIN_PREV: r_cfg.gain_prev <= $signed(i_cfg.data);
                REG_MODEL_CUR: r_cfg.model_cur <= $signed(i_cfg.data);
                REG_MODEL_SPD: r_cfg.model_spd <= $signed(i_cfg.data);
                REG_MODEL_DRV: r_cfg.model_drv <= $signed(i_cfg.data);
                REG_LIMIT:     r_cfg.limit     <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Result register: loaded at commit, emptied when the sink takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (commit_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_o_duty    <= res.duty;
            r_o_clamped <= res.clamped;
        end
    end

    assign o_out_ch.valid   = r_o_valid;
    assign o_out_ch.duty    = r_o_duty;
    assign o_out_ch.clamped = r_o_clamped;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the PI current loop with model-based current estimator.
`timescale 1ns / 1ps

module tb;
    import pilc_pkg::*;

    // This margin covers a result still in flight when the last expected one has been
    // seen, before any register write.
    localparam int SETTLE_CYCLES = 24;
    // Length of the long output stall that backs the block up into its input.
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 100;
    localparam int RANDOM_PHASES = 10;

    // Indexes beyond the last register; writes there must change nothing.
    localparam t_cfg_idx REG_SPARE_LO = 3'd6;
    localparam t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam longint      S32_HI  = 64'sd2147483647;
    localparam longint      S32_LO  = -64'sd2147483648;
    localparam logic [31:0] W_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN   = 32'h8000_0000;
    localparam logic [31:0] W_NEG1  = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE_AMP = 32'h0001_0000;

    logic clk;
    logic rst_n;

    pilc_in_if  in_ch ();
    pilc_out_if out_ch ();
    pilc_cfg_if cfg_ch ();

    pi_current_loop_with_estimator_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg    (cfg_ch)
    );

    // Loop model: the register copy and the four state values that the block carries
    // from one control tick to the next. All state values are Q16.16 held in longint
    // so that the unsaturated sums can be formed exactly before clipping.
    t_cfg   loop_cfg;
    longint est_q;
    longint spd_q;
    longint err_q;
    longint drv_q;

    // Expected duty results in the order the control ticks were accepted.
    t_dp_res pending_duty[$];
    t_dp_res want_res;

    int mismatch_count;
    int result_count;

    // Both sides skip their random idle cycles while no_gaps is set. hold_request
    // asks the result sink for one long stall.
    bit no_gaps;
    bit hold_request;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Loop model.
    // ------------------------------------------------------------------

    // Q16.16 product, rounded half up: add half an LSB and floor-shift the Q32.32 value.
    function automatic longint q_mul(longint a, longint b);
        return (a * b + 64'sd32768) >>> FRAC_W;
    endfunction

    function automatic longint clip32(longint v);
        if (v > S32_HI) begin
            return S32_HI;
        end else if (v < S32_LO) begin
            return S32_LO;
        end
        return v;
    endfunction

    function automatic t_cfg default_settings();
        t_cfg s;
        s.gain_now  = RST_GAIN_NOW;
        s.gain_prev = RST_GAIN_PREV;
        s.model_cur = RST_MODEL_CUR;
        s.model_spd = RST_MODEL_SPD;
        s.model_drv = RST_MODEL_DRV;
        s.limit     = RST_LIMIT;
        return s;
    endfunction

    task automatic reset_model();
        loop_cfg = default_settings();
        est_q    = 0;
        spd_q    = 0;
        err_q    = 0;
        drv_q    = 0;
    endtask

    // Only the low 31 bits of a limit write count; unknown indexes are ignored.
    task automatic set_register_model(input t_cfg_idx idx, input logic [31:0] data);
        case (idx)
            REG_GAIN_NOW:  loop_cfg.gain_now  = data;
            REG_GAIN_PREV: loop_cfg.gain_prev = data;
            REG_MODEL_CUR: loop_cfg.model_cur = data;
            REG_MODEL_SPD: loop_cfg.model_spd = data;
            REG_MODEL_DRV: loop_cfg.model_drv = data;
            REG_LIMIT:     loop_cfg.limit     = data[LIM_W-1:0];
            default: ;
        endcase
    endtask

    // One control tick: error against the old estimate, incremental PI drive, then the
    // estimate advanced with the unclamped new drive plus the last clamped drive.
    task automatic predict_tick(input logic [31:0] target, input logic [31:0] speed,
                                output t_dp_res res);
        longint err;
        longint drv;
        longint dsum;
        longint est;
        longint held;
        longint lim;
        lim  = longint'(loop_cfg.limit);
        err  = clip32(longint'($signed(target)) - est_q);
        drv  = clip32(drv_q + q_mul(longint'($signed(loop_cfg.gain_now)), err)
                      + q_mul(longint'($signed(loop_cfg.gain_prev)), err_q));
        dsum = clip32(drv + drv_q);
        est  = clip32(q_mul(longint'($signed(loop_cfg.model_cur)), est_q)
                      + q_mul(longint'($signed(loop_cfg.model_spd)), spd_q)
                      + q_mul(longint'($signed(loop_cfg.model_drv)), dsum));

        // A drive that lands exactly on zero or on the limit is not flagged.
        held        = drv;
        res.clamped = 1'b0;
        if (held > lim) begin
            held        = lim;
            res.clamped = 1'b1;
        end else if (held < 0) begin
            held        = 0;
            res.clamped = 1'b1;
        end

        est_q    = est;
        spd_q    = longint'($signed(speed));
        err_q    = err;
        drv_q    = held;
        res.duty = DUTY_W'(held >>> DUTY_SH);
    endtask

    // ------------------------------------------------------------------
    // Stimulus values.
    // ------------------------------------------------------------------

    // Any 32 bit word, weighted toward plant-sized values and the corners.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0, 1: w = $urandom();
            2: w = $urandom_range(0, 20 * 65536);
            3: begin
                w = $urandom_range(0, 20 * 65536);
                w = -w;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: w = W_MAX;
                    1: w = W_MIN;
                    2: w = '0;
                    default: w = W_NEG1;
                endcase
            end
            default: w = $urandom_range(0, 255);
        endcase
        return w;
    endfunction

    // Current command between -10 A and +20 A.
    function automatic logic [31:0] typical_target();
        return 32'($urandom_range(0, 30 * 65536)) - 32'd655360;
    endfunction

    // Speed between -200 and +200 units.
    function automatic logic [31:0] typical_speed();
        return 32'($urandom_range(0, 400 * 65536)) - 32'd13107200;
    endfunction

    // Register settings: either small variations of the tuned plant or arbitrary words.
    function automatic t_cfg random_settings(bit wild);
        t_cfg s;
        s = default_settings();
        if (wild) begin
            s.gain_now  = random_word();
            s.gain_prev = random_word();
            s.model_cur = random_word();
            s.model_spd = random_word();
            s.model_drv = random_word();
        end else begin
            s.gain_now  = RST_GAIN_NOW + 32'($urandom_range(0, 4000)) - 32'd2000;
            s.gain_prev = RST_GAIN_PREV + 32'($urandom_range(0, 4000)) - 32'd2000;
            s.model_cur = RST_MODEL_CUR + 32'($urandom_range(0, 6000)) - 32'd3000;
            s.model_spd = RST_MODEL_SPD + 32'($urandom_range(0, 500)) - 32'd250;
            s.model_drv = RST_MODEL_DRV + 32'($urandom_range(0, 8000)) - 32'd4000;
        end
        case ($urandom_range(0, 4))
            0: s.limit = LIM_W'($urandom());
            1: s.limit = LIM_W'($urandom_range(0, 24 * 65536));
            2: s.limit = '0;
            3: s.limit = '1;
            default: s.limit = RST_LIMIT;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers.
    // ------------------------------------------------------------------

    // Offers one control tick and waits for its transaction. The valid stays high
    // afterwards so that back-to-back items need no second assignment in one step;
    // settle_loop lowers it when the stream pauses.
    task automatic send_sample(input logic [31:0] target, input logic [31:0] speed);
        int      gap;
        t_dp_res res;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.target_current <= target;
        in_ch.measured_speed <= speed;
        do @(posedge clk); while (!in_ch.ready);
        predict_tick(target, speed, res);
        pending_duty.push_back(res);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [31:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        set_register_model(idx, data);
    endtask

    task automatic close_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result has come back,
    // then lets the block run out its remaining cycles.
    task automatic settle_loop();
        in_ch.valid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_settings(input t_cfg s);
        settle_loop();
        write_register(REG_GAIN_NOW,  s.gain_now);
        write_register(REG_GAIN_PREV, s.gain_prev);
        write_register(REG_MODEL_CUR, s.model_cur);
        write_register(REG_MODEL_SPD, s.model_spd);
        write_register(REG_MODEL_DRV, s.model_drv);
        write_register(REG_LIMIT,     {1'b0, s.limit});
        close_writes();
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] result %0d: %s, expected %0d, got %0d",
                 $realtime, result_count, what, want, got);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side.
    // ------------------------------------------------------------------

    // The sink draws an idle stretch before each result, or a single long stall when
    // asked, so that the output register fills and the block refuses new items.
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end else if (no_gaps) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 3);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Every result transaction is matched against the oldest expected result.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_duty.size() == 0) begin
                report_mismatch("result with nothing pending, duty", 0, out_ch.duty);
            end else begin
                want_res = pending_duty.pop_front();
                if (out_ch.duty !== want_res.duty) begin
                    report_mismatch("duty", want_res.duty, out_ch.duty);
                end
                if (out_ch.clamped !== want_res.clamped) begin
                    report_mismatch("clamped", want_res.clamped, out_ch.clamped);
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A few ticks with the register values from reset: a plain step response.
    task automatic test_reset_defaults();
        send_sample(32'd0, 32'd0);
        send_sample(ONE_AMP, 32'd0);
        send_sample(32'd327680, 32'd655360);
        send_sample(-32'd131072, -32'd3276800);
        send_sample(32'd1310720, 32'd100);
    endtask

    // With unity error gain and a zero model the drive is the last clamped drive plus
    // the command, which lets the clamp be hit exactly: landing on zero or on the limit
    // must not be flagged, a drive one step past the limit or below zero must be.
    task automatic test_drive_clamps();
        t_cfg s;
        s           = default_settings();
        s.gain_now  = ONE_AMP;
        s.gain_prev = '0;
        s.model_cur = '0;
        s.model_spd = '0;
        s.model_drv = '0;
        program_settings(s);
        send_sample(W_MIN, 32'd0);
        send_sample({1'b0, RST_LIMIT}, 32'd0);
        send_sample(-{1'b0, RST_LIMIT}, 32'd0);
        send_sample({1'b0, RST_LIMIT} + 32'd1, 32'd0);

        // Zero limit: the only unflagged drive is exactly zero.
        s.limit = '0;
        program_settings(s);
        send_sample(W_MIN, 32'd0);
        send_sample(32'd0, 32'd0);
        send_sample(32'd1, 32'd0);

        // Full-scale limit: the saturated sum equals the limit and gives full duty.
        s.limit = '1;
        program_settings(s);
        send_sample(W_MAX, W_MAX);
        send_sample(W_MAX, W_MIN);
    endtask

    // Corners of both input fields with the tuned plant, driving sums into
    // saturation.
    task automatic test_field_extremes();
        program_settings(default_settings());
        send_sample(W_MAX, W_MAX);
        send_sample(W_MIN, W_MIN);
        send_sample(W_MAX, W_MIN);
        send_sample(W_MIN, W_MAX);
        send_sample(32'd0, W_NEG1);
        send_sample(W_NEG1, 32'd0);
        send_sample(W_MAX, 32'd0);
        send_sample(W_MIN, W_NEG1);
    endtask

    // All registers at their extremes. The limit is also written with bit 31 set,
    // which must be dropped, and the two unused indexes are written with junk.
    task automatic test_register_extremes();
        logic [31:0] word;
        logic [31:0] limit_word;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin word = W_MAX;  limit_word = W_NEG1; end
                1: begin word = W_MIN;  limit_word = W_MIN;  end
                2: begin word = '0;     limit_word = '0;     end
                default: begin word = W_NEG1; limit_word = W_MAX; end
            endcase
            settle_loop();
            write_register(REG_GAIN_NOW,  word);
            write_register(REG_GAIN_PREV, word);
            write_register(REG_MODEL_CUR, word);
            write_register(REG_MODEL_SPD, word);
            write_register(REG_MODEL_DRV, word);
            write_register(REG_LIMIT,     limit_word);
            write_register(REG_SPARE_LO,  $urandom());
            write_register(REG_SPARE_HI,  $urandom());
            close_writes();
            for (int k = 0; k < 15; k++) begin
                send_sample(random_word(), random_word());
            end
        end
    endtask

    // A stretch where neither side idles, so items follow at the block's own rate.
    task automatic test_no_idle();
        program_settings(random_settings(1'b0));
        no_gaps = 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_sample(typical_target(), typical_speed());
        end
        settle_loop();
        no_gaps = 1'b0;
    endtask

    // The sink stalls for a long stretch while items keep being offered, so the
    // output register fills and the input must hold off.
    task automatic test_backpressure();
        program_settings(default_settings());
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_sample(typical_target(), typical_speed());
        end
    endtask

    // Phases of random ticks, each under a fresh register setting. Most ticks are
    // plant-sized so the loop state evolves as in a drive; the rest are arbitrary.
    task automatic test_random_settings();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_settings(random_settings(ph % 3 == 2));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_sample(typical_target(), typical_speed());
                end else begin
                    send_sample(random_word(), random_word());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------

    initial begin
        mismatch_count = 0;
        result_count   = 0;
        no_gaps        = 1'b0;
        hold_request   = 1'b0;
        reset_model();

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.target_current <= '0;
        in_ch.measured_speed <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_drive_clamps();
        test_field_extremes();
        test_register_extremes();
        test_no_idle();
        test_backpressure();
        test_random_settings();

        settle_loop();
        if (mismatch_count == 0 && pending_duty.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // This bound ends a run that hangs and reports it as failed.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_duty.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/pilc_pkg.sv
rtl/pilc_if.sv
rtl/pilc_datapath.sv
rtl/pi_current_loop_with_estimator_unit.sv
tb/tb.sv
